/* sv/csr_spmv_scaled_top_assert.svh */
// Assertion macros used by the checker of the scaled sparse product block.
`ifndef CSR_SPMV_SCALED_TOP_ASSERT_SVH
`define CSR_SPMV_SCALED_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SPMV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spmv check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SPMV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spmv check failed");

`endif

/* sv/spmv_pkg.sv */
package spmv_pkg;

  localparam int unsigned MaxNodes = 1024;
  localparam int unsigned VecAw = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;

  localparam int unsigned ValW = 32;
  localparam int unsigned DampW = 17;
  localparam int unsigned NodeW = 11;
  localparam int unsigned RowW = 10;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw = $clog2(QueueDepth);

  // Request codes.
  localparam logic [1:0] ReqVecWrite = 2'd0;
  localparam logic [1:0] ReqNonzero = 2'd1;
  localparam logic [1:0] ReqEmptyRow = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDamping = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgNodeCount = 1'b1;

  localparam logic [DampW-1:0] DampingReset = 17'd55706;
  localparam logic [NodeW-1:0] NodeCountReset = 11'd1024;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [9:0]      vec_index;
    logic [ValW-1:0] entry_value;
    logic [9:0]      column;
    logic            last_in_row;
  } in_item_t;

  typedef struct packed {
    logic [RowW-1:0] row_index;
    logic [ValW-1:0] row_value;
    logic            saturated;
  } out_item_t;

  typedef enum logic {
    KindNonzero,
    KindEmptyRow
  } work_kind_e;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    work_kind_e      kind;
    logic [ValW-1:0] value;
    logic [ValW-1:0] x;
    logic            last;
  } work_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_stat_t;

  typedef enum logic [1:0] {
    StIdle,
    StAccum,
    StScale,
    StFinish
  } back_state_e;

endpackage

/* sv/spmv_front.sv */
module spmv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  spmv_pkg::in_item_t  in_i,
  input  spmv_pkg::queue_stat_t q_stat_i,
  output logic                q_push_o,
  output spmv_pkg::work_t     q_data_o
);
  import spmv_pkg::*;

  logic [ValW-1:0] mem_q [MaxNodes];

  logic            stage_valid_q, stage_valid_d;
  work_kind_e      kind_q;
  logic [ValW-1:0] value_q;
  logic            last_q;
  logic [ValW-1:0] rd_q;
  logic            rd_zero_q;

  logic accept;
  logic move;
  logic is_work;
  logic wr_en;

  assign full_o  = stage_valid_q && q_stat_i.full;
  assign accept  = push_i && !full_o;
  assign move    = stage_valid_q && !q_stat_i.full;
  assign is_work = accept && (in_i.req_type == ReqNonzero || in_i.req_type == ReqEmptyRow);
  assign wr_en   = accept && (in_i.req_type == ReqVecWrite) &&
                   (32'(in_i.vec_index) < MaxNodes);

  assign stage_valid_d = is_work || (stage_valid_q && !move);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[VecAw'(in_i.vec_index)] <= in_i.entry_value;
    end
    if (is_work) begin
      rd_q      <= mem_q[VecAw'(in_i.column)];
      rd_zero_q <= !(32'(in_i.column) < MaxNodes);
      kind_q    <= (in_i.req_type == ReqEmptyRow) ? KindEmptyRow : KindNonzero;
      value_q   <= in_i.entry_value;
      last_q    <= in_i.last_in_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  assign q_push_o       = move;
  assign q_data_o.kind  = kind_q;
  assign q_data_o.value = value_q;
  assign q_data_o.x     = rd_zero_q ? '0 : rd_q;
  assign q_data_o.last  = last_q;

endmodule

/* sv/spmv_queue.sv */
module spmv_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  spmv_pkg::work_t       data_i,
  input  logic                  pop_i,
  output spmv_pkg::work_t       data_o,
  output spmv_pkg::queue_stat_t stat_o
);
  import spmv_pkg::*;

  work_t              entries_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]   count_q, count_d;

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  assign data_o           = entries_q[rd_ptr_q];
  assign stat_o.not_empty = (count_q != '0);
  assign stat_o.full      = (count_q == (QueueAw + 1)'(QueueDepth));

endmodule

/* sv/spmv_back.sv */
module spmv_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spmv_pkg::work_t       q_data_i,
  input  spmv_pkg::queue_stat_t q_stat_i,
  output logic                  q_pop_o,
  input  logic [16:0]           damping_i,
  input  logic [10:0]           node_count_i,
  output spmv_pkg::out_item_t   out_o,
  output logic                  empty_o,
  input  logic                  pop_i
);
  import spmv_pkg::*;

  localparam logic [49:0] RoundBit = 50'd1 << 46;

  back_state_e     state_q, state_d;
  logic [63:0]     prod_q;
  logic            last_q;
  logic [63:0]     sum_q, sum_d;
  logic            clip_q, clip_d;
  logic [RowW-1:0] row_q, row_d;
  logic [48:0]     a_q;
  logic [49:0]     t_q;
  out_item_t       out_q, out_wdata;
  logic            out_valid_q;

  logic            out_free;
  logic            out_wr;
  logic            load_prod;
  logic            load_scale;
  logic [64:0]     sum_ext;
  logic [50:0]     r_sum;
  logic [34:0]     q_val;
  logic [RowW:0]   row_inc;
  logic [RowW-1:0] row_next;
  logic [ValW-1:0] fin_val;
  logic            fin_sat;

  assign out_free = !out_valid_q || pop_i;
  assign sum_ext  = {1'b0, sum_q} + {1'b0, prod_q};
  assign r_sum    = {4'b0, a_q[14:0], 32'b0} + {1'b0, t_q};
  assign q_val    = {1'b0, a_q[48:15]} + 35'(r_sum[50:47]);
  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign row_next = (row_inc >= node_count_i) ? '0 : row_inc[RowW-1:0];

  always_comb begin
    if (clip_q || (q_val[34:32] != 3'b0)) begin
      fin_val = '1;
      fin_sat = 1'b1;
    end else begin
      fin_val = q_val[31:0];
      fin_sat = 1'b0;
    end
  end

  always_comb begin
    state_d    = state_q;
    q_pop_o    = 1'b0;
    out_wr     = 1'b0;
    out_wdata  = '0;
    sum_d      = sum_q;
    clip_d     = clip_q;
    row_d      = row_q;
    load_prod  = 1'b0;
    load_scale = 1'b0;
    case (state_q)
      StIdle: begin
        if (q_stat_i.not_empty) begin
          if (q_data_i.kind == KindEmptyRow) begin
            if (out_free) begin
              q_pop_o             = 1'b1;
              out_wr              = 1'b1;
              out_wdata.row_index = row_q;
              sum_d               = '0;
              clip_d              = 1'b0;
              row_d               = row_next;
            end
          end else begin
            q_pop_o   = 1'b1;
            load_prod = 1'b1;
            state_d   = StAccum;
          end
        end
      end
      StAccum: begin
        if (sum_ext[64]) begin
          sum_d  = '1;
          clip_d = 1'b1;
        end else begin
          sum_d = sum_ext[63:0];
        end
        state_d = last_q ? StScale : StIdle;
      end
      StScale: begin
        load_scale = 1'b1;
        state_d    = StFinish;
      end
      StFinish: begin
        if (out_free) begin
          out_wr              = 1'b1;
          out_wdata.row_index = row_q;
          out_wdata.row_value = fin_val;
          out_wdata.saturated = fin_sat;
          sum_d               = '0;
          clip_d              = 1'b0;
          row_d               = row_next;
          state_d             = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_prod) begin
      prod_q <= q_data_i.value * q_data_i.x;
      last_q <= q_data_i.last;
    end
    if (load_scale) begin
      a_q <= sum_q[63:32] * damping_i;
      t_q <= sum_q[31:0] * damping_i + RoundBit;
    end
    if (out_wr) begin
      out_q <= out_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sum_q       <= '0;
      clip_q      <= 1'b0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      clip_q  <= clip_d;
      row_q   <= row_d;
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o   = out_q;
  assign empty_o = !out_valid_q;

endmodule

/* sv/csr_spmv_scaled_top.sv */
// A nonzero that closes its row passes the front stage, queue, multiply, accumulate,
// scale, then rounding into the result register. In the back-end sequencer a nonzero
// passes StIdle and StAccum, a row end also StScale and StFinish, an empty row StIdle
// only; a vector write uses the front only. The back-end sequencer sets the rate.
// Reset (rst_ni low, asynchronous) clears the row sum, row counter and queue, loads the
// config registers with their reset values, and leaves the vector store unwritten.
module csr_spmv_scaled_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  spmv_pkg::in_item_t  in_i,
  output logic                empty,
  input  logic                pop,
  output spmv_pkg::out_item_t out_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [16:0]         cfg_wdata_i
);
  import spmv_pkg::*;

  // Configuration registers. The user must write them only while the block is idle;
  // the block does not enforce it; the back end reads them directly to scale a row.
  logic [DampW-1:0] damping_q;
  logic [NodeW-1:0] node_count_q;

  // Link between the front end and the work queue, and from the queue to the back end.
  logic        f_push;
  work_t       f_data;
  work_t       q_head;
  queue_stat_t q_stat;
  logic        b_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q    <= DampingReset;
      node_count_q <= NodeCountReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDamping:   damping_q    <= cfg_wdata_i;
        CfgNodeCount: node_count_q <= cfg_wdata_i[NodeW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front end takes each beat while full is low. Vector writes land in the store
  // and end there; nonzeros read their vector element and go, with empty-row markers,
  // into a one-entry stage that feeds the work queue. Unknown requests are dropped.
  spmv_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .q_push_o (f_push),
    .q_data_o (f_data)
  );

  // The short queue lets the front keep loading the vector or reading elements while
  // the back end is busy finishing a row or waits for a result beat to be taken.
  spmv_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .data_i (f_data),
    .pop_i  (b_pop),
    .data_o (q_head),
    .stat_o (q_stat)
  );

  // The back end multiplies, accumulates with saturation, scales the row sum by the
  // damping factor with rounding, and holds each result in an output register.
  spmv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_data_i     (q_head),
    .q_stat_i     (q_stat),
    .q_pop_o      (b_pop),
    .damping_i    (damping_q),
    .node_count_i (node_count_q),
    .out_o        (out_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule

/* sv/spmv_checker.sv */
`include "csr_spmv_scaled_top_assert.svh"

module spmv_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input spmv_pkg::out_item_t out_o
);

  // A result beat that is not taken stays put.
  `SPMV_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_o))

  // A clipped result always carries the largest value.
  `SPMV_ASSERT_NOW(a_sat_max, !empty && out_o.saturated, out_o.row_value == 32'hFFFFFFFF)

  // Back-pressure on the input only rises after an input beat was taken.
  `SPMV_ASSERT_NOW(a_full_cause, $rose(full), $past(push && !full))

endmodule

bind csr_spmv_scaled_top spmv_checker u_spmv_checker (.*);
